// ----- sv/masked_bicubic_interpolator_assert.svh -----
// ----------------------------------------------------------------------------
// Masked bicubic interpolator assertion macros
// Shared concurrent assertion forms used at the top level.
// ----------------------------------------------------------------------------
`ifndef MASKED_BICUBIC_INTERPOLATOR_ASSERT_SVH
`define MASKED_BICUBIC_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define MBI_ASSERT_IMPLY(name, ck, rn, a, b) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("mbi assertion failed");

// next-cycle implication
`define MBI_ASSERT_NEXT(name, ck, rn, a, b) \
    name: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("mbi assertion failed");

`endif

// ----- sv/mbi_pkg.sv -----
// ----------------------------------------------------------------------------
// Masked bicubic interpolator package
// Types, constants and the Catmull-Rom weight function.
// ----------------------------------------------------------------------------
`default_nettype none

package mbi_pkg;

    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS      = 9;
    localparam int BANKS          = 4;
    localparam int BANK_SEL_BITS  = 2;
    localparam int BANK_ADDR_BITS = ROW_BITS + COL_BITS - BANK_SEL_BITS;
    localparam int BANK_DEPTH     = MAX_WIDTH * MAX_HEIGHT / BANKS;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = 1;
    localparam int QCNT_BITS      = 2;

    localparam int FRAC_BITS = 16;
    localparam int WGT_BITS  = 18;
    localparam int WN_BITS   = 54;
    localparam int PROD_BITS = WGT_BITS + 16;
    localparam int RS_BITS   = PROD_BITS + 2;
    localparam int YP_BITS   = RS_BITS + WGT_BITS;
    localparam int ACC_BITS  = YP_BITS + 2;
    localparam int RES_BITS  = 24;

    localparam logic signed [WN_BITS-1:0] K32 = WN_BITS'(1) <<< 32;
    localparam logic signed [WN_BITS-1:0] K49 = WN_BITS'(1) <<< 49;
    localparam logic signed [ACC_BITS-1:0] RND24 = ACC_BITS'(1) <<< 23;
    localparam logic signed [ACC_BITS-1:0] RES_MAX = ACC_BITS'(8388607);
    localparam logic signed [ACC_BITS-1:0] RES_MIN = -ACC_BITS'(8388608);

    typedef enum logic [2:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_Y_ORIGIN = 3'd1,
        CFG_X_INV    = 3'd2,
        CFG_Y_INV    = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5
    } cfg_idx_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [7:0]          pixel_column;
        logic [7:0]          pixel_row;
        logic signed [15:0]  pixel_sample;
        logic                pixel_usable;
        logic signed [31:0]  query_x;
        logic signed [31:0]  query_y;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0]  interpolated;
        logic                point_valid;
    } out_item_t;

    typedef struct packed {
        logic                  opcode;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   row;
        logic signed [15:0]    sample;
        logic                  usable;
        logic                  ok;
        logic [COL_BITS-1:0]   xi;
        logic [ROW_BITS-1:0]   yi;
        logic [FRAC_BITS-1:0]  xf;
        logic [FRAC_BITS-1:0]  yf;
    } job_t;

    typedef logic signed [WGT_BITS-1:0] wgt_t;
    typedef logic [3:0][WGT_BITS-1:0] wgt_vec_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MAP_X,
        F_MAP_Y,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_CUBE,
        B_WGT,
        B_MAC,
        B_FIN,
        B_OUT
    } back_state_t;

    function automatic wgt_vec_t cr_weights(
        input logic [FRAC_BITS-1:0] f,
        input logic [2*FRAC_BITS-1:0] f2,
        input logic [3*FRAC_BITS-1:0] f3
    );
        logic signed [WN_BITS-1:0] sf;
        logic signed [WN_BITS-1:0] sf2;
        logic signed [WN_BITS-1:0] sf3;
        logic signed [WN_BITS-1:0] n0;
        logic signed [WN_BITS-1:0] n1;
        logic signed [WN_BITS-1:0] n2;
        logic signed [WN_BITS-1:0] n3;
        wgt_vec_t w;
        sf  = signed'(WN_BITS'(f));
        sf2 = signed'(WN_BITS'(f2));
        sf3 = signed'(WN_BITS'(f3));
        n0 = -(sf <<< 32) + (sf2 <<< 17) - sf3;
        n1 = K49 - (sf2 <<< 18) - (sf2 <<< 16) + (sf3 <<< 1) + sf3;
        n2 = (sf <<< 32) + (sf2 <<< 18) - (sf3 <<< 1) - sf3;
        n3 = sf3 - (sf2 <<< 16);
        w[0] = WGT_BITS'((n0 + K32) >>> 33);
        w[1] = WGT_BITS'((n1 + K32) >>> 33);
        w[2] = WGT_BITS'((n2 + K32) >>> 33);
        w[3] = WGT_BITS'((n3 + K32) >>> 33);
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mbi_front.sv -----
// ----------------------------------------------------------------------------
// Masked bicubic interpolator front end
// Holds the configuration, accepts transactions and maps queries to the grid.
// ----------------------------------------------------------------------------
`default_nettype none

module mbi_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mbi_pkg::in_item_t in_item,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [31:0]      cfg_data,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output mbi_pkg::job_t         job
);

    mbi_pkg::front_state_t state_reg, state_next;
    mbi_pkg::in_item_t     item_reg;

    logic signed [31:0]                 x_org_reg, y_org_reg;
    logic [31:0]                        x_inv_reg, y_inv_reg;
    logic [mbi_pkg::SIZE_BITS-1:0]      wid_reg, hgt_reg;
    logic [32:0]                        dx_reg, dy_reg;
    logic [mbi_pkg::COL_BITS-1:0]       xi_reg;
    logic [mbi_pkg::ROW_BITS-1:0]       yi_reg;
    logic [mbi_pkg::FRAC_BITS-1:0]      xf_reg, yf_reg;
    logic                               xok_reg, yok_reg;

    logic [32:0]                        mul_d;
    logic [31:0]                        mul_b;
    logic [63:0]                        prod;
    logic [mbi_pkg::SIZE_BITS-1:0]      size_eff;
    logic                               axis_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_org_reg <= '0;
            y_org_reg <= '0;
            x_inv_reg <= 32'd65536;
            y_inv_reg <= 32'd65536;
            wid_reg   <= mbi_pkg::SIZE_BITS'(256);
            hgt_reg   <= mbi_pkg::SIZE_BITS'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (mbi_pkg::cfg_idx_t'(cfg_index))
                mbi_pkg::CFG_X_ORIGIN: x_org_reg <= signed'(cfg_data);
                mbi_pkg::CFG_Y_ORIGIN: y_org_reg <= signed'(cfg_data);
                mbi_pkg::CFG_X_INV:    x_inv_reg <= cfg_data;
                mbi_pkg::CFG_Y_INV:    y_inv_reg <= cfg_data;
                mbi_pkg::CFG_WIDTH:    wid_reg   <= cfg_data[mbi_pkg::SIZE_BITS-1:0];
                mbi_pkg::CFG_HEIGHT:   hgt_reg   <= cfg_data[mbi_pkg::SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // shared 32x32 multiplier, x axis then y axis
    always_comb
    begin
        if (state_reg == mbi_pkg::F_MAP_Y)
        begin
            mul_d    = dy_reg;
            mul_b    = y_inv_reg;
            size_eff = (hgt_reg > mbi_pkg::SIZE_BITS'(mbi_pkg::MAX_HEIGHT)) ?
                       mbi_pkg::SIZE_BITS'(mbi_pkg::MAX_HEIGHT) : hgt_reg;
        end
        else
        begin
            mul_d    = dx_reg;
            mul_b    = x_inv_reg;
            size_eff = (wid_reg > mbi_pkg::SIZE_BITS'(mbi_pkg::MAX_WIDTH)) ?
                       mbi_pkg::SIZE_BITS'(mbi_pkg::MAX_WIDTH) : wid_reg;
        end
        prod    = 64'(mul_d[31:0]) * 64'(mul_b);
        axis_ok = !mul_d[32] && (prod[63:32] != 32'd0) &&
                  ({1'b0, prod[63:32]} + 33'd3 <= 33'(size_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbi_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        job_valid  = 1'b0;
        case (state_reg)
            mbi_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = (in_item.opcode == mbi_pkg::OP_QUERY) ?
                                 mbi_pkg::F_MAP_X : mbi_pkg::F_PUSH;
            end
            mbi_pkg::F_MAP_X: state_next = mbi_pkg::F_MAP_Y;
            mbi_pkg::F_MAP_Y: state_next = mbi_pkg::F_PUSH;
            mbi_pkg::F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                    state_next = mbi_pkg::F_IDLE;
            end
            default: state_next = mbi_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mbi_pkg::F_IDLE && in_valid)
        begin
            item_reg <= in_item;
            dx_reg   <= {in_item.query_x[31], in_item.query_x} - {x_org_reg[31], x_org_reg};
            dy_reg   <= {in_item.query_y[31], in_item.query_y} - {y_org_reg[31], y_org_reg};
        end
        if (state_reg == mbi_pkg::F_MAP_X)
        begin
            xi_reg  <= prod[32 +: mbi_pkg::COL_BITS];
            xf_reg  <= prod[31:16];
            xok_reg <= axis_ok;
        end
        if (state_reg == mbi_pkg::F_MAP_Y)
        begin
            yi_reg  <= prod[32 +: mbi_pkg::ROW_BITS];
            yf_reg  <= prod[31:16];
            yok_reg <= axis_ok;
        end
    end

    always_comb
    begin
        job.opcode = item_reg.opcode;
        job.col    = item_reg.pixel_column[mbi_pkg::COL_BITS-1:0];
        job.row    = item_reg.pixel_row[mbi_pkg::ROW_BITS-1:0];
        job.sample = item_reg.pixel_sample;
        job.usable = item_reg.pixel_usable;
        job.ok     = xok_reg && yok_reg;
        job.xi     = xi_reg;
        job.yi     = yi_reg;
        job.xf     = xf_reg;
        job.yf     = yf_reg;
    end

endmodule

`default_nettype wire

// ----- sv/mbi_queue.sv -----
// ----------------------------------------------------------------------------
// Masked bicubic interpolator job queue
// Short FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbi_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push_valid,
    output logic                            push_ready,
    input  wire mbi_pkg::job_t              push_job,
    output logic                            pop_valid,
    input  wire logic                       pop_ready,
    output mbi_pkg::job_t                   pop_job,
    output logic [mbi_pkg::QCNT_BITS-1:0]   count
);

    mbi_pkg::job_t                    slot_reg [mbi_pkg::QUEUE_DEPTH];
    logic [mbi_pkg::QPTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [mbi_pkg::QCNT_BITS-1:0]    cnt_reg;
    logic                             push, pop;

    assign push_ready = (cnt_reg != mbi_pkg::QCNT_BITS'(mbi_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign count      = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// ----- sv/mbi_back.sv -----
// ----------------------------------------------------------------------------
// Masked bicubic interpolator back end
// Four-banked pixel store, weight generation and 4x4 multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module mbi_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire mbi_pkg::job_t  job,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mbi_pkg::out_item_t  out_item
);

    mbi_pkg::back_state_t state_reg, state_next;
    mbi_pkg::job_t        job_reg;
    mbi_pkg::out_item_t   res_reg, out_reg;
    logic                 out_valid_reg;

    logic [2*mbi_pkg::FRAC_BITS-1:0] f2x_reg, f2y_reg;
    logic [3*mbi_pkg::FRAC_BITS-1:0] f3x_reg, f3y_reg;
    mbi_pkg::wgt_vec_t               wx_reg, wy_reg;

    logic [2:0]   rd_cnt_reg;
    logic         rd_en;
    logic         v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]   k1_reg, k2_reg, k3_reg;
    logic         mask_ok_reg;
    logic signed [mbi_pkg::PROD_BITS-1:0] prod_reg [4];
    logic signed [mbi_pkg::RS_BITS-1:0]   rs_reg;
    logic signed [mbi_pkg::YP_BITS-1:0]   yp_reg;
    logic signed [mbi_pkg::ACC_BITS-1:0]  acc_reg;
    logic signed [mbi_pkg::ACC_BITS-1:0]  rnd;

    logic [mbi_pkg::COL_BITS-1:0]       base_col;
    logic [mbi_pkg::ROW_BITS-1:0]       rd_row;
    logic [mbi_pkg::BANKS-1:0][16:0]    bank_rd;
    logic                               wr_en;
    logic                               accept;

    assign accept    = (state_reg == mbi_pkg::B_IDLE) && job_valid;
    assign wr_en     = accept && (job.opcode == mbi_pkg::OP_WRITE);
    assign rd_en     = (state_reg == mbi_pkg::B_MAC) && !rd_cnt_reg[2];
    assign base_col  = job_reg.xi - 1'b1;
    assign rd_row    = job_reg.yi - 1'b1 + mbi_pkg::ROW_BITS'(rd_cnt_reg[1:0]);

    for (genvar b = 0; b < mbi_pkg::BANKS; b++)
    begin : g_bank
        logic [16:0]                        mem [mbi_pkg::BANK_DEPTH];
        logic [16:0]                        rd_q;
        logic [mbi_pkg::BANK_SEL_BITS-1:0]  off;
        logic [mbi_pkg::COL_BITS-1:0]       col;

        assign off = mbi_pkg::BANK_SEL_BITS'(b) - base_col[mbi_pkg::BANK_SEL_BITS-1:0];
        assign col = base_col + mbi_pkg::COL_BITS'(off);

        always_ff @(posedge clk)
        begin
            if (wr_en && job.col[mbi_pkg::BANK_SEL_BITS-1:0] == mbi_pkg::BANK_SEL_BITS'(b))
                mem[{job.row, job.col[mbi_pkg::COL_BITS-1:mbi_pkg::BANK_SEL_BITS]}] <=
                    {job.usable, job.sample};
            if (rd_en)
                rd_q <= mem[{rd_row, col[mbi_pkg::COL_BITS-1:mbi_pkg::BANK_SEL_BITS]}];
        end

        assign bank_rd[b] = rd_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbi_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mbi_pkg::B_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == mbi_pkg::B_WGT)
                rd_cnt_reg <= '0;
            else if (rd_en)
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        case (state_reg)
            mbi_pkg::B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid && job.opcode == mbi_pkg::OP_QUERY)
                    state_next = job.ok ? mbi_pkg::B_SQ : mbi_pkg::B_OUT;
            end
            mbi_pkg::B_SQ:   state_next = mbi_pkg::B_CUBE;
            mbi_pkg::B_CUBE: state_next = mbi_pkg::B_WGT;
            mbi_pkg::B_WGT:  state_next = mbi_pkg::B_MAC;
            mbi_pkg::B_MAC:
            begin
                if (rd_cnt_reg[2] && !v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    state_next = mbi_pkg::B_FIN;
            end
            mbi_pkg::B_FIN:  state_next = mbi_pkg::B_OUT;
            mbi_pkg::B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = mbi_pkg::B_IDLE;
            end
            default: state_next = mbi_pkg::B_IDLE;
        endcase
    end

    assign rnd = (acc_reg + mbi_pkg::RND24) >>> 24;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job;
            res_reg <= '0;
        end
        if (state_reg == mbi_pkg::B_SQ)
        begin
            f2x_reg <= 32'(job_reg.xf) * 32'(job_reg.xf);
            f2y_reg <= 32'(job_reg.yf) * 32'(job_reg.yf);
        end
        if (state_reg == mbi_pkg::B_CUBE)
        begin
            f3x_reg <= 48'(f2x_reg) * 48'(job_reg.xf);
            f3y_reg <= 48'(f2y_reg) * 48'(job_reg.yf);
        end
        if (state_reg == mbi_pkg::B_WGT)
        begin
            wx_reg      <= mbi_pkg::cr_weights(job_reg.xf, f2x_reg, f3x_reg);
            wy_reg      <= mbi_pkg::cr_weights(job_reg.yf, f2y_reg, f3y_reg);
            mask_ok_reg <= 1'b1;
            acc_reg     <= '0;
        end
        k1_reg <= rd_cnt_reg[1:0];
        k2_reg <= k1_reg;
        k3_reg <= k2_reg;
        if (v1_reg)
        begin
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= $signed(bank_rd[2'(base_col[1:0] + 2'(j))][15:0]) *
                               $signed(wx_reg[j]);
            end
            mask_ok_reg <= mask_ok_reg & bank_rd[0][16] & bank_rd[1][16] &
                           bank_rd[2][16] & bank_rd[3][16];
        end
        if (v2_reg)
            rs_reg <= mbi_pkg::RS_BITS'(prod_reg[0]) + mbi_pkg::RS_BITS'(prod_reg[1]) +
                      mbi_pkg::RS_BITS'(prod_reg[2]) + mbi_pkg::RS_BITS'(prod_reg[3]);
        if (v3_reg)
            yp_reg <= rs_reg * $signed(wy_reg[k3_reg]);
        if (v4_reg)
            acc_reg <= acc_reg + mbi_pkg::ACC_BITS'(yp_reg);
        if (state_reg == mbi_pkg::B_FIN)
        begin
            if (!mask_ok_reg)
                res_reg <= '0;
            else
            begin
                res_reg.point_valid <= 1'b1;
                if (rnd > mbi_pkg::RES_MAX)
                    res_reg.interpolated <= mbi_pkg::RES_BITS'(mbi_pkg::RES_MAX);
                else if (rnd < mbi_pkg::RES_MIN)
                    res_reg.interpolated <= mbi_pkg::RES_BITS'(mbi_pkg::RES_MIN);
                else
                    res_reg.interpolated <= mbi_pkg::RES_BITS'(rnd);
            end
        end
        if (state_reg == mbi_pkg::B_OUT && (!out_valid_reg || out_ready))
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ----- sv/masked_bicubic_interpolator.sv -----
// ----------------------------------------------------------------------------
// Masked bicubic interpolator
// Catmull-Rom bicubic sampling of a masked 256x256 image of signed samples.
// ----------------------------------------------------------------------------
// A write transaction stores one pixel and its usable bit and gives no result;
// a query maps its world point onto the grid and returns one result, the
// Q.8 saturated bicubic value with point_valid, or zero with point_valid low
// when the point is near or past the edge or touches an unusable pixel. Each
// end takes one item at a time: the front end maps a query with one shared
// 32x32 multiplier, x then y; the back end serves it with four row reads of
// the four-banked store and the multiply-accumulate pipeline behind them.
// A two-entry queue lets the two ends overlap.
// The store has no reset; every pixel a query touches must have been written.
`default_nettype none

`include "masked_bicubic_interpolator_assert.svh"

module masked_bicubic_interpolator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire mbi_pkg::in_item_t    in_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output mbi_pkg::out_item_t        out_item,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);

    logic                               f_job_valid, q_push_ready;
    mbi_pkg::job_t                      f_job, q_job;
    logic                               q_pop_valid, b_job_ready;
    logic [mbi_pkg::QCNT_BITS-1:0]      q_count;

    mbi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (f_job_valid),
        .job_ready (q_push_ready),
        .job       (f_job)
    );

    mbi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_job_valid),
        .push_ready (q_push_ready),
        .push_job   (f_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (b_job_ready),
        .pop_job    (q_job),
        .count      (q_count)
    );

    mbi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_pop_valid),
        .job_ready (b_job_ready),
        .job       (q_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    `MBI_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, out_valid && !out_item.point_valid, out_item.interpolated == '0)
    `MBI_ASSERT_IMPLY(a_queue_bound, clk, rst_n, 1'b1, q_count <= mbi_pkg::QCNT_BITS'(mbi_pkg::QUEUE_DEPTH))
    `MBI_ASSERT_IMPLY(a_full_stall, clk, rst_n, f_job_valid && !q_push_ready, q_count == mbi_pkg::QCNT_BITS'(mbi_pkg::QUEUE_DEPTH))
    `MBI_ASSERT_NEXT(a_drain, clk, rst_n, q_count == 1 && q_pop_valid && b_job_ready && !(f_job_valid && q_push_ready), !q_pop_valid)

endmodule

`default_nettype wire

// ----- sim/masked_bicubic_interpolator_tb.sv -----
// ----------------------------------------------------------------------------
// Masked bicubic interpolator testbench
// Loads 4x4 pixel patches, queries points inside and around them under a
// series of grid mappings and image sizes, and checks each result against a
// Catmull-Rom predictor kept inside the bench, with random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module masked_bicubic_interpolator_tb;

    typedef longint wvec_t [4];

    localparam int QC_INVALID   = 0;
    localparam int QC_READABLE  = 1;
    localparam int QC_UNWRITTEN = 2;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    mbi_pkg::in_item_t    in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    mbi_pkg::out_item_t   out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    masked_bicubic_interpolator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // image shadow
    logic signed [15:0] px_sample [65536];
    bit                 px_usable [65536];
    bit                 px_written [65536];

    // register shadow
    logic signed [31:0] x_org = 0;
    logic signed [31:0] y_org = 0;
    logic [31:0]        x_inv = 32'd65536;
    logic [31:0]        y_inv = 32'd65536;
    logic [8:0]         img_w = 9'd256;
    logic [8:0]         img_h = 9'd256;

    mbi_pkg::out_item_t expected_results [$];
    int  mismatches = 0;
    int  n_writes = 0;
    int  n_queries = 0;
    int  n_valid = 0;
    int  n_configs = 0;
    int  n_checked = 0;
    bit  idle_on = 1'b1;
    bit  hold_toggle = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    initial forever #5 clk = ~clk;

    function automatic longint axis_size(input logic [8:0] r, input longint mx);
        return (longint'(r) < mx) ? longint'(r) : mx;
    endfunction

    function automatic bit map_coord(input logic signed [31:0] c,
                                     input logic signed [31:0] o,
                                     input logic [31:0] inv, input longint sz,
                                     output longint idx, output longint frac);
        longint     d;
        logic [63:0] p;
        d = longint'(c) - longint'(o);
        idx = 0;
        frac = 0;
        if (d < 0) return 1'b0;
        p = 64'(d) * 64'(inv);
        idx = longint'(p[63:32]);
        frac = longint'(p[31:16]);
        return (idx >= 1 && idx <= sz - 3);
    endfunction

    function automatic wvec_t cr_weights_q16(input longint f);
        longint f2, f3;
        longint n [4];
        wvec_t  w;
        f2 = f * f;
        f3 = f2 * f;
        n[0] = -f * (64'sd1 << 32) + 2 * f2 * (64'sd1 << 16) - f3;
        n[1] = 2 * (64'sd1 << 48) - 5 * f2 * (64'sd1 << 16) + 3 * f3;
        n[2] = f * (64'sd1 << 32) + 4 * f2 * (64'sd1 << 16) - 3 * f3;
        n[3] = -f2 * (64'sd1 << 16) + f3;
        for (int i = 0; i < 4; i++)
            w[i] = (n[i] + (64'sd1 << 32)) >>> 33;
        return w;
    endfunction

    // invalid, fully readable, or in bounds but touching an unwritten pixel
    function automatic int query_class(input logic signed [31:0] qx,
                                       input logic signed [31:0] qy);
        longint xi, yi, xf, yf;
        bit     okx, oky;
        okx = map_coord(qx, x_org, x_inv, axis_size(img_w, mbi_pkg::MAX_WIDTH), xi, xf);
        oky = map_coord(qy, y_org, y_inv, axis_size(img_h, mbi_pkg::MAX_HEIGHT), yi, yf);
        if (!(okx && oky)) return QC_INVALID;
        for (int k = 0; k < 4; k++)
            for (int j = 0; j < 4; j++)
                if (!px_written[(yi - 1 + k) * mbi_pkg::MAX_WIDTH + (xi - 1 + j)])
                    return QC_UNWRITTEN;
        return QC_READABLE;
    endfunction

    function automatic mbi_pkg::out_item_t predict_bicubic(input mbi_pkg::in_item_t it);
        longint             xi, yi, xf, yf, total, rs, r;
        wvec_t              wx, wy;
        bit                 ok;
        mbi_pkg::out_item_t res;
        res = '0;
        ok = map_coord(it.query_x, x_org, x_inv, axis_size(img_w, mbi_pkg::MAX_WIDTH),
                       xi, xf);
        ok = map_coord(it.query_y, y_org, y_inv, axis_size(img_h, mbi_pkg::MAX_HEIGHT),
                       yi, yf) && ok;
        if (ok)
            for (int k = 0; k < 4; k++)
                for (int j = 0; j < 4; j++)
                    if (!px_usable[(yi - 1 + k) * mbi_pkg::MAX_WIDTH + (xi - 1 + j)])
                        ok = 1'b0;
        if (!ok) return res;
        wx = cr_weights_q16(xf);
        wy = cr_weights_q16(yf);
        total = 0;
        for (int k = 0; k < 4; k++) begin
            rs = 0;
            for (int j = 0; j < 4; j++)
                rs += wx[j] * longint'(px_sample[(yi - 1 + k) * mbi_pkg::MAX_WIDTH
                                                 + (xi - 1 + j)]);
            total += wy[k] * rs;
        end
        r = (total + (64'sd1 << 23)) >>> 24;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        res.interpolated = r[23:0];
        res.point_valid = 1'b1;
        return res;
    endfunction

    task automatic send_item(input mbi_pkg::in_item_t it);
        while (idle_on && $urandom_range(0, 99) < 29) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        if (it.opcode == mbi_pkg::OP_WRITE) begin
            px_sample[{it.pixel_row, it.pixel_column}] = it.pixel_sample;
            px_usable[{it.pixel_row, it.pixel_column}] = it.pixel_usable;
            px_written[{it.pixel_row, it.pixel_column}] = 1'b1;
            n_writes++;
        end else begin
            expected_results.push_back(predict_bicubic(it));
            n_queries++;
        end
    endtask

    task automatic write_pixel(input int c, input int r, input logic [15:0] s,
                               input bit u);
        mbi_pkg::in_item_t it;
        it = {$urandom, $urandom, $urandom, 2'($urandom)};
        it.opcode = mbi_pkg::OP_WRITE;
        it.pixel_column = c[7:0];
        it.pixel_row = r[7:0];
        it.pixel_sample = s;
        it.pixel_usable = u;
        send_item(it);
    endtask

    task automatic query_point(input logic signed [31:0] qx,
                               input logic signed [31:0] qy);
        mbi_pkg::in_item_t it;
        it = {$urandom, $urandom, $urandom, 2'($urandom)};
        it.opcode = mbi_pkg::OP_QUERY;
        it.query_x = qx;
        it.query_y = qy;
        // never touch an unwritten pixel: fall back to the origin column
        if (query_class(qx, qy) == QC_UNWRITTEN) it.query_x = x_org;
        send_item(it);
    endtask

    function automatic logic signed [31:0] coord_for(input longint idx,
                                                      input logic signed [31:0] o,
                                                      input logic [31:0] inv);
        longint tgt, d, c;
        if (inv == 0) return o;
        tgt = (idx << 32) | (longint'($urandom_range(0, 65535)) << 16)
              | longint'($urandom_range(0, 65535));
        d = (tgt + longint'(inv) - 1) / longint'(inv);
        c = longint'(o) + d;
        if (c > 64'sd2147483647) return o;
        return c[31:0];
    endfunction

    task automatic set_config(input logic signed [31:0] xo, input logic signed [31:0] yo,
                              input logic [31:0] xs, input logic [31:0] ys,
                              input logic [8:0] w, input logic [8:0] h);
        logic [31:0] vals [6];
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        vals = '{xo, yo, xs, ys, {23'd0, w}, {23'd0, h}};
        for (int i = mbi_pkg::CFG_X_ORIGIN; i <= mbi_pkg::CFG_HEIGHT; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= mbi_pkg::cfg_idx_t'(i);
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            n_configs++;
        end
        cfg_valid <= 1'b0;
        x_org = xo;
        y_org = yo;
        x_inv = xs;
        y_inv = ys;
        img_w = w;
        img_h = h;
    endtask

    function automatic logic [15:0] patch_sample(input int mode, input int c, input int r);
        case (mode)
            0: return ((c + r) % 2) ? 16'h8000 : 16'h7fff;
            1: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_patch(input int bc, input int br, input bit all_usable);
        int mode;
        int hole;
        mode = $urandom_range(0, 5);
        hole = all_usable ? -1 : $urandom_range(0, 15);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                write_pixel(bc + c, br + r, patch_sample(mode, c, r), (r * 4 + c) != hole);
    endtask

    task automatic test_directed();
        load_patch(0, 0, 1'b1);
        query_point(32'h0001_0000, 32'h0001_0000);
        query_point(32'h0001_8000, 32'h0001_8000);
        query_point(32'h0001_ffff, 32'h0001_0001);
        query_point(32'hffff_ffff, 32'h0001_0000);
        query_point(32'h0000_ffff, 32'h0001_0000);
        query_point(32'h7fff_ffff, 32'h8000_0000);
        write_pixel(2, 2, 16'h0000, 1'b0);
        query_point(32'h0001_4000, 32'h0001_c000);
        write_pixel(255, 255, 16'h8000, 1'b1);
    endtask

    task automatic run_random(input int n_items);
        int done;
        int bc, br, nq;
        longint wmax, hmax;
        done = 0;
        while (done < n_items) begin
            wmax = axis_size(img_w, mbi_pkg::MAX_WIDTH);
            hmax = axis_size(img_h, mbi_pkg::MAX_HEIGHT);
            if ($urandom_range(0, 99) < 70) begin
                bc = (wmax >= 4 && $urandom_range(0, 9) < 8) ?
                     $urandom_range(0, int'(wmax) - 4) : $urandom_range(0, 252);
                br = (hmax >= 4 && $urandom_range(0, 9) < 8) ?
                     $urandom_range(0, int'(hmax) - 4) : $urandom_range(0, 252);
                load_patch(bc, br, $urandom_range(0, 9) != 0);
                nq = $urandom_range(3, 8);
                for (int q = 0; q < nq; q++)
                    query_point(coord_for(bc + 1, x_org, x_inv),
                                coord_for(br + 1, y_org, y_inv));
                done += 16 + nq;
            end else if ($urandom_range(0, 1)) begin
                query_point($urandom, $urandom);
                done++;
            end else begin
                write_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                            16'($urandom), $urandom_range(0, 1));
                done++;
            end
        end
    endtask

    task automatic test_default_map();
        idle_on = 1'b0;
        run_random(100);
        idle_on = 1'b1;
        run_random(200);
    endtask

    task automatic test_output_hold_off();
        set_config(-32'sd5 <<< 16, 32'sd3 <<< 16, 32'd65536, 32'd65536, 9'd256, 9'd256);
        hold_toggle = ~hold_toggle;
        run_random(250);
    endtask

    task automatic test_scaled_map();
        set_config(32'sh8000_0000, 32'sh8000_0000, 32'd40000, 32'd98304, 9'd4, 9'd256);
        run_random(200);
    endtask

    task automatic test_extreme_map();
        set_config(32'sh7fff_ffff, 32'sh7ffe_0000, 32'hffff_ffff, 32'h0000_0001,
                   9'd511, 9'd9);
        run_random(100);
        set_config(32'sh0000_1234, 32'shffff_0000, 32'd1, 32'd0, 9'd0, 9'd3);
        run_random(80);
    endtask

    task automatic test_random_map();
        for (int i = 0; i < 3; i++) begin
            set_config($urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 1 << 20)),
                       32'($urandom_range(0, 1 << 20)) - 32'(1 << 19),
                       $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                       9'($urandom_range(4, 300)), 9'($urandom_range(4, 300)));
            run_random(70);
        end
    endtask

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= 400;
            out_ready <= 1'b0;
        end else begin
            out_ready <= !(idle_on && $urandom_range(0, 99) < 29);
        end
    end

    always @(posedge clk) begin
        mbi_pkg::out_item_t exp_res;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: interpolated=%0d point_valid=%0b",
                             out_item.interpolated, out_item.point_valid);
            end else begin
                exp_res = expected_results.pop_front();
                n_checked++;
                if (exp_res.point_valid) n_valid++;
                if (out_item.interpolated !== exp_res.interpolated
                    || out_item.point_valid !== exp_res.point_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %0d/%0b, got %0d/%0b", n_checked,
                                 exp_res.interpolated, exp_res.point_valid,
                                 out_item.interpolated, out_item.point_valid);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_default_map();
        test_output_hold_off();
        test_scaled_map();
        test_extreme_map();
        test_random_map();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("%0d pixel writes, %0d queries (%0d valid), %0d register writes",
                 n_writes, n_queries, n_valid, n_configs);
        $display("%0d results checked, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
